>>> hw/rtl/afr_pkg.sv
// Shared types and constants for the addressed frame receiver.
`default_nettype none
package afr_pkg;

  // Receiver phase; codes 6 and 7 never arise and behave as hunting
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_ADDR    = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  // Event code reported with every received byte
  typedef enum logic [2:0] {
    EV_IGNORED = 3'd0,
    EV_FRAMING = 3'd1,
    EV_PAYLOAD = 3'd2,
    EV_GOOD    = 3'd3,
    EV_BAD     = 3'd4,
    EV_DROPPED = 3'd5
  } event_t;

  // Configuration register indexes
  localparam logic [1:0] REG_STATION_ADDRESS = 2'd0;
  localparam logic [1:0] REG_SYNC_FIRST      = 2'd1;
  localparam logic [1:0] REG_SYNC_SECOND     = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0] STATION_ADDRESS_RST = 8'h00;
  localparam logic [7:0] SYNC_FIRST_RST      = 8'hFF;
  localparam logic [7:0] SYNC_SECOND_RST     = 8'hFE;

  // Payload length is L minus the header, address, length and checksum bytes
  localparam logic [7:0] FRAME_OVERHEAD = 8'd5;

  // Configuration as seen by the parser
  typedef struct packed {
    logic [7:0] station_address;
    logic [7:0] sync_first;
    logic [7:0] sync_second;
  } cfg_t;

endpackage
`default_nettype wire

>>> hw/rtl/afr_cfg.sv
// Configuration register file of the addressed frame receiver.
`default_nettype none
module afr_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [7:0]    cfg_data,
  output afr_pkg::cfg_t      cfg
);

  // Writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.station_address <= afr_pkg::STATION_ADDRESS_RST;
      cfg.sync_first      <= afr_pkg::SYNC_FIRST_RST;
      cfg.sync_second     <= afr_pkg::SYNC_SECOND_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        afr_pkg::REG_STATION_ADDRESS: cfg.station_address <= cfg_data;
        afr_pkg::REG_SYNC_FIRST:      cfg.sync_first      <= cfg_data;
        afr_pkg::REG_SYNC_SECOND:     cfg.sync_second     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/afr_in_reg.sv
// Input register stage holding one received byte for the parser.
`default_nettype none
module afr_in_reg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            hold_valid,
  output logic [7:0]      hold_byte,
  input  wire logic       take
);

  // Room when empty or when the held byte moves on this cycle
  assign in_ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  // Payload capture on transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= rx_byte;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/afr_parser.sv
// Frame parser: phase tracking, checksum, and result register.
`default_nettype none
module afr_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire afr_pkg::cfg_t cfg,
  input  wire logic          hold_valid,
  input  wire logic [7:0]    hold_byte,
  output logic               take,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [2:0]         event_res,
  output logic [7:0]         data_byte,
  output logic [7:0]         payload_index
);

  afr_pkg::phase_t phase, phase_next;
  logic [7:0]      running_sum, running_sum_next;
  logic [7:0]      frame_length, frame_length_next;
  logic [7:0]      bytes_seen, bytes_seen_next;
  afr_pkg::event_t ev_next;
  logic [7:0]      idx_next;
  logic [7:0]      seen_inc;
  logic [7:0]      payload_len;

  // Held byte moves into the result register when that register is free
  assign take = hold_valid && (!out_valid || out_ready);

  assign seen_inc    = bytes_seen + 8'd1;
  assign payload_len = frame_length - afr_pkg::FRAME_OVERHEAD;

  // Next state and event for the held byte
  always_comb begin
    phase_next        = phase;
    running_sum_next  = running_sum;
    frame_length_next = frame_length;
    bytes_seen_next   = bytes_seen;
    ev_next           = afr_pkg::EV_IGNORED;
    idx_next          = 8'd0;
    unique case (phase)
      afr_pkg::PH_SYNC2: begin
        if (hold_byte == cfg.sync_second) begin
          ev_next          = afr_pkg::EV_FRAMING;
          running_sum_next = running_sum + hold_byte;
          phase_next       = afr_pkg::PH_ADDR;
        end else begin
          ev_next    = afr_pkg::EV_DROPPED;
          phase_next = afr_pkg::PH_HUNT;
        end
      end
      afr_pkg::PH_ADDR: begin
        if (hold_byte == cfg.station_address) begin
          ev_next          = afr_pkg::EV_FRAMING;
          running_sum_next = running_sum + hold_byte;
          phase_next       = afr_pkg::PH_LEN;
        end else begin
          ev_next    = afr_pkg::EV_DROPPED;
          phase_next = afr_pkg::PH_HUNT;
        end
      end
      afr_pkg::PH_LEN: begin
        ev_next           = afr_pkg::EV_FRAMING;
        running_sum_next  = running_sum + hold_byte;
        frame_length_next = hold_byte;
        bytes_seen_next   = 8'd0;
        // no payload when L is five or less
        phase_next = (hold_byte > afr_pkg::FRAME_OVERHEAD) ?
                     afr_pkg::PH_PAYLOAD : afr_pkg::PH_CHECK;
      end
      afr_pkg::PH_PAYLOAD: begin
        // frame_length exceeds the overhead here, so payload_len is positive
        ev_next          = afr_pkg::EV_PAYLOAD;
        idx_next         = bytes_seen;
        running_sum_next = running_sum + hold_byte;
        bytes_seen_next  = seen_inc;
        if (seen_inc >= payload_len) begin
          phase_next = afr_pkg::PH_CHECK;
        end
      end
      afr_pkg::PH_CHECK: begin
        ev_next    = (hold_byte == running_sum) ? afr_pkg::EV_GOOD : afr_pkg::EV_BAD;
        phase_next = afr_pkg::PH_HUNT;
      end
      default: begin
        // hunting, also covers the unused phase codes
        if (hold_byte == cfg.sync_first) begin
          ev_next           = afr_pkg::EV_FRAMING;
          running_sum_next  = hold_byte;
          frame_length_next = 8'd0;
          bytes_seen_next   = 8'd0;
          phase_next        = afr_pkg::PH_SYNC2;
        end else begin
          ev_next    = afr_pkg::EV_IGNORED;
          phase_next = afr_pkg::PH_HUNT;
        end
      end
    endcase
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= afr_pkg::PH_HUNT;
      running_sum  <= 8'd0;
      frame_length <= 8'd0;
      bytes_seen   <= 8'd0;
    end else if (take) begin
      phase        <= phase_next;
      running_sum  <= running_sum_next;
      frame_length <= frame_length_next;
      bytes_seen   <= bytes_seen_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      event_res     <= 3'(ev_next);
      data_byte     <= hold_byte;
      payload_index <= idx_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/addressed_frame_receiver.sv
// Top level of the addressed frame receiver.
//
//   channel  signals                          direction
//   in       in_valid/in_ready, rx_byte       byte stream into the block
//   out      out_valid/out_ready, event_res,  one event per received byte
//            data_byte, payload_index
//   cfg      cfg_valid/cfg_ready, cfg_index,  register writes, always ready
//            cfg_data
//
// One byte per cycle sustained while out is not stalled; a result passes from the
// input register through the parser logic into the result register, and is
// presented there until it transfers on out.
// rst clears the phase, checksum, counters, stage valids and configuration registers.
// A stall on out backs up through the input register to in_ready.
`default_nettype none
module addressed_frame_receiver (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      event_res,
  output logic [7:0]      data_byte,
  output logic [7:0]      payload_index,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  afr_pkg::cfg_t cfg;
  logic          hold_valid;
  logic [7:0]    hold_byte;
  logic          take;

  afr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  afr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte),
    .take       (take)
  );

  afr_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .hold_valid    (hold_valid),
    .hold_byte     (hold_byte),
    .take          (take),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_res     (event_res),
    .data_byte     (data_byte),
    .payload_index (payload_index)
  );

endmodule
`default_nettype wire
